/* rtl/mbr_pkg.sv */
package mbr_pkg;

    // field and datapath widths
    localparam int COORD_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int DIM_WIDTH   = 12;
    localparam int SIZE_WIDTH  = 13;
    localparam int FRAC_BITS   = 27;
    localparam int ZW          = 48;   // c and z registers, Q.27
    localparam int ZOP_W       = FRAC_BITS + 2;   // z operand once inside |z| < 2
    localparam int SQ_W        = 2 * ZOP_W;
    localparam int DIV_W       = 33;
    localparam int DEN_W       = 16;
    localparam int ADDR_WIDTH  = 5;
    localparam int DATA_WIDTH  = 32;
    localparam int T_W         = 17;   // t and u, 65536 stands for one
    localparam int K_W         = 13;

    // colour weights: 9*255, 15*255, 17*255 (blue then takes one more shift)
    localparam logic [K_W-1:0] K_RED   = 13'd2295;
    localparam logic [K_W-1:0] K_GREEN = 13'd3825;
    localparam logic [K_W-1:0] K_BLUE  = 13'd4335;

    // register indexes
    localparam logic [2:0] REG_MIN_REAL   = 3'd0;
    localparam logic [2:0] REG_MAX_REAL   = 3'd1;
    localparam logic [2:0] REG_MIN_IMAG   = 3'd2;
    localparam logic [2:0] REG_MAX_IMAG   = 3'd3;
    localparam logic [2:0] REG_WIDTH      = 3'd4;
    localparam logic [2:0] REG_HEIGHT     = 3'd5;
    localparam logic [2:0] REG_MAX_ITER   = 3'd6;

    // divider operand selection
    localparam logic [1:0] DIV_SEL_RE = 2'd0;
    localparam logic [1:0] DIV_SEL_IM = 2'd1;
    localparam logic [1:0] DIV_SEL_T  = 2'd2;

    typedef struct packed {
        logic [DIM_WIDTH-1:0] pixel_x;
        logic [DIM_WIDTH-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] iteration_count;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
    } pixel_out_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] min_real;
        logic [COORD_WIDTH-1:0] max_real;
        logic [COORD_WIDTH-1:0] min_imag;
        logic [COORD_WIDTH-1:0] max_imag;
        logic [SIZE_WIDTH-1:0]  image_width;
        logic [SIZE_WIDTH-1:0]  image_height;
        logic [COUNT_WIDTH-1:0] max_iterations;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic [1:0] div_sel;
        logic       map_re;
        logic       map_im;
        logic       iter_init;
        logic       iter_step;
        logic       col1;
        logic       col2;
        logic       col3;
        logic       load_out;
    } mbr_cmd_t;

    typedef struct packed {
        logic div_done;
        logic iter_done;
    } mbr_status_t;

endpackage

/* rtl/mbr_div.sv */
module mbr_div
    import mbr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[DIV_W-1]};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

/* rtl/mbr_datapath.sv */
module mbr_datapath
    import mbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mbr_cmd_t    cmd,
    input  cfg_t        cfg,
    input  pixel_in_t   pixel,
    output mbr_status_t status,
    output pixel_out_t  result
);

    localparam logic signed [ZW-1:0]   TWO  = ZW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0]   MTWO = -TWO;
    localparam logic signed [SQ_W:0]   FOUR = (SQ_W + 1)'(1) <<< (2 * FRAC_BITS + 2);

    logic [DIM_WIDTH-1:0]   px_reg, py_reg;
    logic signed [ZW-1:0]   cr_reg, ci_reg, zr_reg, zi_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [2*T_W-1:0]       tt_reg, ut_reg, uu_reg;
    logic [63:0]            pr_reg, pg_reg, pb_reg;
    logic [44:0]            rh_reg, rl_reg, gh_reg, gl_reg, bh_reg, bl_reg;
    pixel_out_t             out_reg;

    // divider operands
    logic signed [DIV_W-1:0] diff_re, diff_im;
    logic [DIV_W-1:0]        div_a;
    logic [DEN_W-1:0]        div_d;
    logic [DIV_W-1:0]        div_q;
    logic                    div_done;

    assign diff_re = $signed({cfg.max_real[COORD_WIDTH-1], cfg.max_real})
                   - $signed({cfg.min_real[COORD_WIDTH-1], cfg.min_real});
    assign diff_im = $signed({cfg.max_imag[COORD_WIDTH-1], cfg.max_imag})
                   - $signed({cfg.min_imag[COORD_WIDTH-1], cfg.min_imag});

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEL_RE:
            begin
                div_a = diff_re[DIV_W-1] ? DIV_W'(-diff_re) : DIV_W'(diff_re);
                div_d = (cfg.image_width == '0) ? DEN_W'(1) : DEN_W'(cfg.image_width);
            end
            DIV_SEL_IM:
            begin
                div_a = diff_im[DIV_W-1] ? DIV_W'(-diff_im) : DIV_W'(diff_im);
                div_d = (cfg.image_height == '0) ? DEN_W'(1) : DEN_W'(cfg.image_height);
            end
            DIV_SEL_T:
            begin
                div_a = {1'b0, count_reg, 16'b0};
                div_d = cfg.max_iterations;
            end
            default:
            begin
                div_a = '0;
                div_d = DEN_W'(1);
            end
        endcase
    end

    mbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // axis map: c = index*step + min
    logic                     map_neg;
    logic [DIM_WIDTH-1:0]     map_idx;
    logic [COORD_WIDTH-1:0]   map_lo;
    logic signed [DIV_W:0]    step;
    logic signed [DIV_W+DIM_WIDTH+1:0] map_prod;
    logic signed [ZW-1:0]     map_c;

    always_comb
    begin
        map_neg  = cmd.map_im ? diff_im[DIV_W-1] : diff_re[DIV_W-1];
        map_idx  = cmd.map_im ? py_reg : px_reg;
        map_lo   = cmd.map_im ? cfg.min_imag : cfg.min_real;
        step     = map_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        map_prod = $signed({1'b0, map_idx}) * step;
        map_c    = ZW'(map_prod) + ZW'($signed(map_lo));
    end

    // one escape iteration
    logic signed [ZOP_W-1:0] zr_op, zi_op;
    logic signed [SQ_W-1:0]  sr, si, sx;
    logic signed [SQ_W:0]    ssum, sdif;
    logic                    big, limit_hit;
    logic signed [ZW-1:0]    zr_new, zi_new;

    always_comb
    begin
        zr_op     = zr_reg[ZOP_W-1:0];
        zi_op     = zi_reg[ZOP_W-1:0];
        sr        = zr_op * zr_op;
        si        = zi_op * zi_op;
        sx        = zr_op * zi_op;
        ssum      = (SQ_W + 1)'(sr) + (SQ_W + 1)'(si);
        sdif      = (SQ_W + 1)'(sr) - (SQ_W + 1)'(si);
        big       = (zr_reg >= TWO) || (zr_reg <= MTWO) || (zi_reg >= TWO) || (zi_reg <= MTWO);
        limit_hit = (count_reg == cfg.max_iterations);
        zr_new    = ZW'(sdif >>> FRAC_BITS) + cr_reg;
        zi_new    = ZW'(sx >>> (FRAC_BITS - 1)) + ci_reg;
    end

    assign status.div_done  = div_done;
    assign status.iter_done = limit_hit || big || (ssum >= FOUR);

    // colour polynomial terms
    logic [T_W-1:0]     t_val, u_val;
    logic [4*T_W-1:0]   pr_full, pg_full, pb_full;
    logic [45:0]        r_acc, g_acc, b_acc;

    always_comb
    begin
        t_val   = div_q[T_W-1:0];
        u_val   = T_W'(17'h10000) - t_val;
        pr_full = ut_reg * tt_reg;
        pg_full = uu_reg * tt_reg;
        pb_full = uu_reg * ut_reg;
        r_acc   = {1'b0, rh_reg} + 46'(rl_reg[44:32]);
        g_acc   = {1'b0, gh_reg} + 46'(gl_reg[44:32]);
        b_acc   = {1'b0, bh_reg} + 46'(bl_reg[44:32]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg <= pixel.pixel_x;
            py_reg <= pixel.pixel_y;
        end
        if (cmd.map_re)
        begin
            cr_reg <= map_c;
        end
        if (cmd.map_im)
        begin
            ci_reg <= map_c;
        end
        if (cmd.iter_init)
        begin
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.iter_step)
        begin
            zr_reg    <= zr_new;
            zi_reg    <= zi_new;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.col1)
        begin
            tt_reg <= {{T_W{1'b0}}, t_val} * {{T_W{1'b0}}, t_val};
            ut_reg <= {{T_W{1'b0}}, u_val} * {{T_W{1'b0}}, t_val};
            uu_reg <= {{T_W{1'b0}}, u_val} * {{T_W{1'b0}}, u_val};
        end
        if (cmd.col2)
        begin
            pr_reg <= pr_full[63:0];
            pg_reg <= pg_full[63:0];
            pb_reg <= pb_full[63:0];
        end
        if (cmd.col3)
        begin
            rh_reg <= pr_reg[63:32] * K_RED;
            rl_reg <= pr_reg[31:0]  * K_RED;
            gh_reg <= pg_reg[63:32] * K_GREEN;
            gl_reg <= pg_reg[31:0]  * K_GREEN;
            bh_reg <= pb_reg[63:32] * K_BLUE;
            bl_reg <= pb_reg[31:0]  * K_BLUE;
        end
        if (cmd.load_out)
        begin
            out_reg.iteration_count <= count_reg;
            if (cfg.max_iterations == '0)
            begin
                out_reg.red   <= '0;
                out_reg.green <= '0;
                out_reg.blue  <= '0;
            end
            else
            begin
                out_reg.red   <= r_acc[39:32];
                out_reg.green <= g_acc[39:32];
                out_reg.blue  <= b_acc[40:33];
            end
        end
    end

    assign result = out_reg;

endmodule

/* rtl/mbr_ctrl.sv */
module mbr_ctrl
    import mbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  mbr_status_t status,
    output mbr_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV_RE = 4'd1;
    localparam logic [3:0] S_MAP_RE = 4'd2;
    localparam logic [3:0] S_DIV_IM = 4'd3;
    localparam logic [3:0] S_MAP_IM = 4'd4;
    localparam logic [3:0] S_ITER   = 4'd5;
    localparam logic [3:0] S_DIV_T  = 4'd6;
    localparam logic [3:0] S_COL1   = 4'd7;
    localparam logic [3:0] S_COL2   = 4'd8;
    localparam logic [3:0] S_COL3   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg && !result_ready;
        cmd         = '0;
        cmd.div_sel = DIV_SEL_RE;
        pixel_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.load_in   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_RE;
                end
            end
            S_DIV_RE:
            begin
                if (status.div_done)
                begin
                    state_next = S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                cmd.map_re    = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_IM;
                state_next    = S_DIV_IM;
            end
            S_DIV_IM:
            begin
                if (status.div_done)
                begin
                    state_next = S_MAP_IM;
                end
            end
            S_MAP_IM:
            begin
                cmd.map_im    = 1'b1;
                cmd.iter_init = 1'b1;
                state_next    = S_ITER;
            end
            S_ITER:
            begin
                if (status.iter_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_T;
                    state_next    = S_DIV_T;
                end
                else
                begin
                    cmd.iter_step = 1'b1;
                end
            end
            S_DIV_T:
            begin
                if (status.div_done)
                begin
                    state_next = S_COL1;
                end
            end
            S_COL1:
            begin
                cmd.col1   = 1'b1;
                state_next = S_COL2;
            end
            S_COL2:
            begin
                cmd.col2   = 1'b1;
                state_next = S_COL3;
            end
            S_COL3:
            begin
                cmd.col3   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to be free
                if (!valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

/* rtl/mbr_regs.sv */
module mbr_regs
    import mbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_WIDTH-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_real       <= 32'hF000_0000;
            cfg_reg.max_real       <= 32'h0800_0000;
            cfg_reg.min_imag       <= 32'hF800_0000;
            cfg_reg.max_imag       <= 32'h0800_0000;
            cfg_reg.image_width    <= 13'd640;
            cfg_reg.image_height   <= 13'd480;
            cfg_reg.max_iterations <= 16'd255;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MIN_REAL: cfg_reg.min_real       <= pwdata;
                REG_MAX_REAL: cfg_reg.max_real       <= pwdata;
                REG_MIN_IMAG: cfg_reg.min_imag       <= pwdata;
                REG_MAX_IMAG: cfg_reg.max_imag       <= pwdata;
                REG_WIDTH:    cfg_reg.image_width    <= pwdata[SIZE_WIDTH-1:0];
                REG_HEIGHT:   cfg_reg.image_height   <= pwdata[SIZE_WIDTH-1:0];
                REG_MAX_ITER: cfg_reg.max_iterations <= pwdata[COUNT_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            REG_MIN_REAL: prdata = cfg_reg.min_real;
            REG_MAX_REAL: prdata = cfg_reg.max_real;
            REG_MIN_IMAG: prdata = cfg_reg.min_imag;
            REG_MAX_IMAG: prdata = cfg_reg.max_imag;
            REG_WIDTH:    prdata = DATA_WIDTH'(cfg_reg.image_width);
            REG_HEIGHT:   prdata = DATA_WIDTH'(cfg_reg.image_height);
            REG_MAX_ITER: prdata = DATA_WIDTH'(cfg_reg.max_iterations);
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/mandelbrot_pixel_colour.sv */
// Mandelbrot escape-time evaluator with polynomial colouring.
// Input channel pixel/pixel_valid/pixel_ready carries one (pixel_x, pixel_y)
// beat; output channel result/result_valid/result_ready returns one beat
// with the iteration count and the red, green and blue values.
// The APB port sets the complex window, image size and iteration limit;
// write it only while no pixel is in flight. pready is tied high.
// One pixel is worked on at a time. From accept to result it makes three
// passes of the shared bit-serial divider (real step, imaginary step,
// t = count/limit), runs n escape iterations at one per cycle, n being at
// most max_iterations, and takes the mapping and colour multiply steps.
// A new pixel is taken as soon as the previous result is in the output
// register, so a stalled receiver holds only that register; the block
// then waits in its last step until the register frees up.
// Reset restores the default window (-2..1, -1..1), 640x480, limit 255,
// and clears all control state.
module mandelbrot_pixel_colour
    import mbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pixel_in_t             pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pixel_out_t            result
);

    cfg_t        cfg;
    mbr_cmd_t    cmd;
    mbr_status_t status;

    mbr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mbr_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .pixel  (pixel),
        .status (status),
        .result (result)
    );

endmodule
